FILE: rtl/bst_pkg.sv
// Shared constants and types for the swept box brush trace block.
// No dependencies; the multiplier, divider, top level and bench import this package.
package bst_pkg;

  localparam int MAX_PLANES_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int VW = 32;  // width of a Q16.16 coordinate
  localparam int PW_MUL = 50;  // floor(a*b/65536) of two 33-bit signed operands
  localparam int AW = 56;  // distance accumulator width
  localparam int NW = 58;  // divider operand width
  localparam int CPW = 6;  // width of the reported clip plane index

  localparam logic [15:0] EPS_RESET = 16'd2048;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_DELTA  = 2'd1;
  localparam logic [1:0] CMD_EXTENT = 2'd2;
  localparam logic [1:0] CMD_PLANE  = 2'd3;

  typedef struct packed {
    logic                 start;
    logic signed [NW-1:0] num;
    logic signed [NW-1:0] den;
  } div_req_t;

endpackage

FILE: rtl/bst_item_if.sv
// Input channel of the trace block: valid/ready plus one command or plane beat.
// Depends on nothing.
interface bst_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] plane_dist;
  logic               is_bevel;
  logic               point_mode;
  logic               last_plane;

  modport source (output valid, cmd, vec_x, vec_y, vec_z, plane_dist, is_bevel,
                  point_mode, last_plane, input ready);
  modport sink (input valid, cmd, vec_x, vec_y, vec_z, plane_dist, is_bevel,
                point_mode, last_plane, output ready);
endinterface

FILE: rtl/bst_result_if.sv
// Result channel of the trace block: valid/ready plus one trace result beat.
// Fraction width follows FRAC_BITS.
interface bst_result_if #(parameter int FRAC_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 start_solid;
  logic                 all_solid;
  logic [FRAC_BITS:0]   fraction;
  logic [5:0]           clip_plane;

  modport source (output valid, hit, start_solid, all_solid, fraction, clip_plane,
                  input ready);
  modport sink (input valid, hit, start_solid, all_solid, fraction, clip_plane,
                output ready);
endinterface

FILE: rtl/bst_mul.sv
// Shared registered multiplier: floor(a*b / 65536) of two Q16.16 operands.
// Uses bst_pkg widths.
module bst_mul (
  input  logic                          clk,
  input  logic signed [32:0]            a,
  input  logic signed [32:0]            b,
  output logic signed [bst_pkg::PW_MUL-1:0] p
);
  import bst_pkg::*;

  logic signed [65:0] prod;

  assign prod = a * b;

  // dropping the low 16 bits of a two's complement product is a floor
  always_ff @(posedge clk) begin
    p <= prod[65:16];
  end
endmodule

FILE: rtl/bst_div.sv
// Iterative restoring divider for saturated signed fractions, one bit a cycle.
// Uses bst_pkg for the request struct and operand width.
module bst_div #(
  parameter int FRAC_BITS = bst_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bst_pkg::div_req_t         req,
  output logic                      done,
  output logic signed [FRAC_BITS+1:0] q
);
  import bst_pkg::*;

  localparam int CW = $clog2(FRAC_BITS);
  localparam logic [FRAC_BITS:0] QONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [4:0] {
    D_IDLE = 5'b00001,
    D_ABS  = 5'b00010,
    D_CMP  = 5'b00100,
    D_ITER = 5'b01000,
    D_OUT  = 5'b10000
  } dstate_t;

  dstate_t              state;
  logic signed [NW-1:0] num;
  logic signed [NW-1:0] den;
  logic [NW-1:0]        un;
  logic [NW-1:0]        ud;
  logic                 neg;
  logic [NW:0]          r;
  logic [NW:0]          r_shift;
  logic [FRAC_BITS:0]   qm;
  logic [CW-1:0]        cnt;

  assign r_shift = {r[NW-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      case (state)
        D_IDLE: begin
          if (req.start) begin
            num   <= req.num;
            den   <= req.den;
            state <= D_ABS;
          end
        end
        D_ABS: begin
          un    <= num[NW-1] ? NW'(-num) : NW'(num);
          ud    <= den[NW-1] ? NW'(-den) : NW'(den);
          neg   <= num[NW-1] ^ den[NW-1];
          state <= D_CMP;
        end
        D_CMP: begin
          if (ud == '0) begin
            qm    <= '0;
            state <= D_OUT;
          end else if (un >= ud) begin
            qm    <= QONE;
            state <= D_OUT;
          end else begin
            r     <= {1'b0, un};
            qm    <= '0;
            cnt   <= '0;
            state <= D_ITER;
          end
        end
        D_ITER: begin
          if (r_shift >= {1'b0, ud}) begin
            r  <= r_shift - {1'b0, ud};
            qm <= {qm[FRAC_BITS-1:0], 1'b1};
          end else begin
            r  <= r_shift;
            qm <= {qm[FRAC_BITS-1:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(FRAC_BITS - 1)) begin
            state <= D_OUT;
          end
        end
        D_OUT: begin
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  assign done = (state == D_OUT);
  assign q    = neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});

  a_cmp_follows_abs: assert property (@(posedge clk) disable iff (rst)
    state == D_ABS |=> state == D_CMP)
    else $error("divider skipped its compare step");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (state == D_IDLE && req.start) |=> state == D_ABS)
    else $error("divider did not take a request");
  a_out_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("divider done held for more than one cycle");
endmodule

FILE: rtl/swept_box_brush_trace.sv
// Top level of the swept box brush trace: command decode, sequencer, state.
// Depends on bst_pkg, bst_item_if, bst_result_if, bst_mul and bst_div.
//
// Usage: command beats on the item channel set the segment start (which also
// begins a new brush), the delta, and the box extents with point mode. Plane
// beats follow, one half-space each; the beat with last_plane set closes the
// brush and yields one beat on the result channel. wr_en/wr_data write the
// distance epsilon at any idle time.
// Command beats and skipped planes need no multiplier or divider work.
// A used plane runs nine products through the one shared multiplier and a
// distance step, then, when it crosses the plane, the one-bit-a-cycle
// divider. The closing plane then passes to the emit step, which loads the
// result register once it is free. item.ready is low while a plane is in work.
// Reset clears the segment, extents, mode and trace state; epsilon is 2048.
// A stalled result holds; the block keeps taking beats, and a second result
// waits until the first has been taken.
module swept_box_brush_trace #(
  parameter int MAX_PLANES = bst_pkg::MAX_PLANES_DEF,
  parameter int FRAC_BITS  = bst_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [15:0]   wr_data,
  bst_item_if.sink      item,
  bst_result_if.source  result
);
  import bst_pkg::*;

  localparam int PCW = $clog2(MAX_PLANES);
  localparam int FW  = FRAC_BITS + 2;
  localparam logic signed [FW-1:0] ONE = {2'b00, {FRAC_BITS{1'b0}}} | (FW'(1) << FRAC_BITS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_D12  = 6'b000100,
    S_PREP = 6'b001000,
    S_DIV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t               state;
  logic [15:0]          eps;
  logic signed [VW-1:0] seg_start [3];
  logic signed [VW-1:0] seg_end [3];
  logic signed [VW-1:0] box_extent [3];
  logic signed [VW-1:0] nrm [3];
  logic                 ray_mode;
  logic                 lastp;
  logic                 entering;
  logic [3:0]           k;
  logic [PCW-1:0]       plane_count;
  logic [PCW-1:0]       idx;
  logic [PCW-1:0]       best_plane;
  logic signed [FW-1:0] enter_frac;
  logic signed [FW-1:0] leave_frac;
  logic                 startout;
  logic                 getout;
  logic                 rejected;
  logic signed [AW-1:0] acc1;
  logic signed [AW-1:0] acc2;
  logic signed [NW-1:0] d2;
  logic signed [NW-1:0] d1;

  logic                 take;
  logic                 skip;
  logic [1:0]           j;
  logic [3:0]           pk;
  logic signed [32:0]   mul_a;
  logic signed [32:0]   mul_b;
  logic signed [32:0]   nj;
  logic signed [PW_MUL-1:0] prod;
  logic signed [AW-1:0] prod_x;
  div_req_t             dreq;
  logic                 div_done;
  logic signed [FW-1:0] div_q;
  logic signed [FW-1:0] f_enter;
  logic                 out_free;
  logic                 r_hit;
  logic                 r_ss;
  logic                 r_as;
  logic [FRAC_BITS:0]   r_frac;
  logic [CPW-1:0]       r_cp;

  assign item.ready = (state == S_IDLE);
  assign take       = item.valid && item.ready;
  assign skip       = rejected || (ray_mode && item.is_bevel);
  assign out_free   = !result.valid || result.ready;

  // operand select for product k: extents by |n|, start by n, delta by n
  always_comb begin
    if (k < 4'd3) begin
      j = k[1:0];
    end else if (k < 4'd6) begin
      j = 2'(k - 4'd3);
    end else begin
      j = 2'(k - 4'd6);
    end
    if (j > 2'd2) begin
      j = 2'd0;
    end
    nj = {nrm[j][VW-1], nrm[j]};
    if (k < 4'd3) begin
      mul_a = {box_extent[j][VW-1], box_extent[j]};
      mul_b = nj[32] ? -nj : nj;
    end else if (k < 4'd6) begin
      mul_a = {seg_start[j][VW-1], seg_start[j]};
      mul_b = nj;
    end else begin
      mul_a = {seg_end[j][VW-1], seg_end[j]};
      mul_b = nj;
    end
  end

  bst_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign pk     = k - 4'd1;
  assign prod_x = {{(AW-PW_MUL){prod[PW_MUL-1]}}, prod};
  assign d1     = {{(NW-AW){acc1[AW-1]}}, acc1};

  always_comb begin
    dreq.start = 1'b0;
    dreq.den   = d1 - d2;
    if (d1 > d2) begin
      dreq.num = d1 - NW'(eps);
    end else begin
      dreq.num = d1 + NW'(eps);
    end
    if (state == S_PREP && !(d1 > 0 && d2 >= d1) && !(d1 <= 0 && d2 <= 0)) begin
      dreq.start = 1'b1;
    end
  end

  bst_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (div_done),
    .q    (div_q)
  );

  assign f_enter = div_q[FW-1] ? '0 : div_q;

  // result fields from the closing trace state
  always_comb begin
    r_hit  = 1'b0;
    r_ss   = 1'b0;
    r_as   = 1'b0;
    r_frac = ONE[FRAC_BITS:0];
    r_cp   = '0;
    if (!rejected) begin
      if (!startout) begin
        r_hit  = 1'b1;
        r_ss   = 1'b1;
        r_as   = !getout;
        r_frac = '0;
      end else if (enter_frac < leave_frac && enter_frac > -ONE && enter_frac < ONE) begin
        r_hit  = 1'b1;
        r_frac = enter_frac[FRAC_BITS:0];
        r_cp   = CPW'(best_plane);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      eps         <= EPS_RESET;
      ray_mode    <= 1'b0;
      enter_frac  <= -ONE;
      leave_frac  <= ONE;
      best_plane  <= '0;
      plane_count <= '0;
      startout    <= 1'b0;
      getout      <= 1'b0;
      rejected    <= 1'b0;
      result.valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        seg_start[i]  <= '0;
        seg_end[i]    <= '0;
        box_extent[i] <= '0;
      end
    end else begin
      if (wr_en) begin
        eps <= wr_data;
      end
      // drop the taken beat; the emit step reloads it on its own
      if (result.valid && result.ready && state != S_EMIT) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            case (item.cmd)
              CMD_START: begin
                seg_start[0] <= item.vec_x;
                seg_start[1] <= item.vec_y;
                seg_start[2] <= item.vec_z;
                enter_frac   <= -ONE;
                leave_frac   <= ONE;
                best_plane   <= '0;
                plane_count  <= '0;
                startout     <= 1'b0;
                getout       <= 1'b0;
                rejected     <= 1'b0;
              end
              CMD_DELTA: begin
                seg_end[0] <= item.vec_x;
                seg_end[1] <= item.vec_y;
                seg_end[2] <= item.vec_z;
              end
              CMD_EXTENT: begin
                box_extent[0] <= item.vec_x;
                box_extent[1] <= item.vec_y;
                box_extent[2] <= item.vec_z;
                ray_mode      <= item.point_mode;
              end
              default: begin
                idx         <= plane_count;
                plane_count <= (plane_count == PCW'(MAX_PLANES - 1)) ? '0
                                                                     : plane_count + 1'b1;
                nrm[0] <= item.vec_x;
                nrm[1] <= item.vec_y;
                nrm[2] <= item.vec_z;
                lastp  <= item.last_plane;
                acc1   <= -{{(AW-VW){item.plane_dist[VW-1]}}, item.plane_dist};
                acc2   <= '0;
                k      <= '0;
                if (skip) begin
                  state <= item.last_plane ? S_EMIT : S_IDLE;
                end else begin
                  state <= S_MUL;
                end
              end
            endcase
          end
        end
        S_MUL: begin
          // accumulate the registered product of the previous k
          if (k != 4'd0) begin
            if (pk < 4'd3) begin
              if (!ray_mode) begin
                acc1 <= acc1 - prod_x;
              end
            end else if (pk < 4'd6) begin
              acc1 <= acc1 + prod_x;
            end else begin
              acc2 <= acc2 + prod_x;
            end
          end
          k <= k + 4'd1;
          if (k == 4'd9) begin
            state <= S_D12;
          end
        end
        S_D12: begin
          d2    <= {{(NW-AW){acc1[AW-1]}}, acc1} + {{(NW-AW){acc2[AW-1]}}, acc2};
          state <= S_PREP;
        end
        S_PREP: begin
          if (d2 > 0) begin
            getout <= 1'b1;
          end
          if (d1 > 0) begin
            startout <= 1'b1;
          end
          entering <= d1 > d2;
          if (d1 > 0 && d2 >= d1) begin
            rejected <= 1'b1;
            state    <= lastp ? S_EMIT : S_IDLE;
          end else if (d1 <= 0 && d2 <= 0) begin
            state <= lastp ? S_EMIT : S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (entering) begin
              if (f_enter > enter_frac) begin
                enter_frac <= f_enter;
                best_plane <= idx;
              end
            end else if (div_q < leave_frac) begin
              leave_frac <= div_q;
            end
            state <= lastp ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          // hold until the result register is free, then load and restart
          if (out_free) begin
            result.valid       <= 1'b1;
            result.hit         <= r_hit;
            result.start_solid <= r_ss;
            result.all_solid   <= r_as;
            result.fraction    <= r_frac;
            result.clip_plane  <= r_cp;
            enter_frac  <= -ONE;
            leave_frac  <= ONE;
            best_plane  <= '0;
            plane_count <= '0;
            startout    <= 1'b0;
            getout      <= 1'b0;
            rejected    <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide step");
  a_plane_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (take && item.cmd == CMD_PLANE && !skip) |=> state == S_MUL)
    else $error("used plane did not start the product sequence");
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> result.valid)
    else $error("closing plane produced no result beat");
  a_enter_range: assert property (@(posedge clk) disable iff (rst)
    (enter_frac >= -ONE) && (enter_frac <= ONE))
    else $error("enter fraction out of range");
endmodule

FILE: test/swept_box_brush_trace_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for swept_box_brush_trace: random and directed segments and brushes.
// Depends on bst_pkg, bst_item_if, bst_result_if and the block itself.
module swept_box_brush_trace_tb;
  import bst_pkg::*;

  localparam int PLANES = 64;
  localparam int FB = 16;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic        hit;
    logic        start_solid;
    logic        all_solid;
    logic [16:0] fraction;
    logic [5:0]  clip_plane;
  } trace_res_t;

  class trace_scoreboard;
    trace_res_t pending[$];
    int         errors;
    longint     eps;
    longint     s[3], dv[3], ext[3];
    bit         ray;
    longint     enter_f, leave_f;
    int         best, count;
    bit         startout, getout, rejected;

    function new();
      errors = 0;
      eps = 2048;
      for (int j = 0; j < 3; j++) begin
        s[j] = 0; dv[j] = 0; ext[j] = 0;
      end
      ray = 0;
      restart();
    endfunction

    function void restart();
      enter_f = -ONE;
      leave_f = ONE;
      best = 0;
      count = 0;
      startout = 0; getout = 0; rejected = 0;
    endfunction

    function longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      return p >>> 16;
    endfunction

    function longint quotient(longint num, longint den);
      longint un, ud, r, q;
      bit neg;
      if (den == 0) return 0;
      neg = (num < 0) != (den < 0);
      un = num < 0 ? -num : num;
      ud = den < 0 ? -den : den;
      if (un >= ud) q = ONE;
      else begin
        r = un;
        q = 0;
        for (int i = 0; i < FB; i++) begin
          r = r <<< 1;
          q = q <<< 1;
          if (r >= ud) begin
            r = r - ud;
            q = q | 1;
          end
        end
      end
      return neg ? -q : q;
    endfunction

    function void use_plane(longint n[3], longint pd, int idx);
      longint offs, d1, d2, f;
      offs = pd;
      d1 = 0;
      if (!ray)
        for (int j = 0; j < 3; j++) offs += qmul(ext[j], n[j] < 0 ? -n[j] : n[j]);
      for (int j = 0; j < 3; j++) d1 += qmul(s[j], n[j]);
      d1 -= offs;
      d2 = d1;
      for (int j = 0; j < 3; j++) d2 += qmul(dv[j], n[j]);
      if (d2 > 0) getout = 1;
      if (d1 > 0) startout = 1;
      if (d1 > 0 && d2 >= d1) begin
        rejected = 1;
        return;
      end
      if (d1 <= 0 && d2 <= 0) return;
      if (d1 > d2) begin
        f = quotient(d1 - eps, d1 - d2);
        if (f < 0) f = 0;
        if (f > enter_f) begin
          enter_f = f;
          best = idx;
        end
      end else begin
        f = quotient(d1 + eps, d1 - d2);
        if (f < leave_f) leave_f = f;
      end
    endfunction

    function void note_item(logic [1:0] cmd, logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic signed [31:0] pd,
                            bit bev, bit pm, bit last);
      longint v[3];
      int idx;
      trace_res_t r;
      v[0] = x; v[1] = y; v[2] = z;
      case (cmd)
        CMD_START: begin
          for (int j = 0; j < 3; j++) s[j] = v[j];
          restart();
        end
        CMD_DELTA: for (int j = 0; j < 3; j++) dv[j] = v[j];
        CMD_EXTENT: begin
          for (int j = 0; j < 3; j++) ext[j] = v[j];
          ray = pm;
        end
        default: begin
          idx = count;
          count = (count + 1) % PLANES;
          if (!rejected && !(ray && bev)) use_plane(v, longint'(pd), idx);
          if (last) begin
            r = '0;
            r.fraction = 17'(ONE);
            if (!rejected) begin
              if (!startout) begin
                r.hit = 1;
                r.start_solid = 1;
                r.all_solid = !getout;
                r.fraction = 0;
              end else if (enter_f < leave_f && enter_f > -ONE && enter_f < ONE) begin
                r.hit = 1;
                r.fraction = 17'(enter_f < 0 ? 0 : enter_f);
                r.clip_plane = 6'(best);
              end
            end
            pending.push_back(r);
            restart();
          end
        end
      endcase
    endfunction

    function void check(trace_res_t got);
      trace_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk, rst, wr_en;
  logic [15:0] wr_data;
  bst_item_if item ();
  bst_result_if #(.FRAC_BITS(FB)) result ();

  swept_box_brush_trace dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_data(wr_data),
    .item(item.sink), .result(result.source)
  );

  trace_scoreboard sb = new();
  int send_idle = 0, recv_idle = 0;
  bit hold_req = 0;
  int stall_cycles = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold;
    trace_res_t got;
    hold = 0;
    result.ready <= 0;
    forever begin
      @(posedge clk);
      if (result.valid && result.ready) begin
        got = '{result.hit, result.start_solid, result.all_solid, result.fraction,
                result.clip_plane};
        sb.check(got);
      end
      if (hold_req) begin
        hold = 400;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        result.ready <= 0;
      end else result.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((item.valid && item.ready) || (result.valid && result.ready) || rst)
        stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send(logic [1:0] cmd, logic signed [31:0] x, logic signed [31:0] y,
                      logic signed [31:0] z, logic signed [31:0] pd,
                      bit bev, bit pm, bit last);
    while ($urandom_range(99) < send_idle) begin
      item.valid <= 0;
      @(posedge clk);
    end
    item.valid <= 1;
    item.cmd <= cmd;
    item.vec_x <= x;
    item.vec_y <= y;
    item.vec_z <= z;
    item.plane_dist <= pd;
    item.is_bevel <= bev;
    item.point_mode <= pm;
    item.last_plane <= last;
    do @(posedge clk); while (!item.ready);
    sb.note_item(cmd, x, y, z, pd, bev, pm, last);
  endtask

  task automatic go_quiet();
    item.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_eps(logic [15:0] v);
    go_quiet();
    wr_en <= 1;
    wr_data <= v;
    @(posedge clk);
    wr_en <= 0;
    sb.eps = v;
  endtask

  // mostly modest coordinates, sometimes whole integers, sometimes any bit pattern
  function automatic logic signed [31:0] coord();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return $signed(32'($urandom_range(1 << 23))) - (1 << 22);
    if (sel < 8) return ($signed(32'($urandom_range(40))) - 20) <<< 16;
    return $urandom;
  endfunction

  function automatic logic signed [31:0] normal();
    if ($urandom_range(9) == 0) return $urandom;
    return $signed(32'($urandom_range(1 << 17))) - (1 << 16);
  endfunction

  task automatic plane(bit last);
    send(CMD_PLANE, normal(), normal(), normal(), coord(), $urandom_range(3) == 0,
         $urandom_range(1), last);
  endtask

  task automatic brush();
    int n;
    n = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 7);
    if ($urandom_range(2) == 0)
      send(CMD_START, coord(), coord(), coord(), $urandom, $urandom_range(1),
           $urandom_range(1), $urandom_range(1));
    if ($urandom_range(2) == 0)
      send(CMD_DELTA, coord(), coord(), coord(), $urandom, $urandom_range(1),
           $urandom_range(1), $urandom_range(1));
    if ($urandom_range(3) == 0)
      send(CMD_EXTENT, coord() >>> 2, coord() >>> 2, coord() >>> 2, $urandom,
           $urandom_range(1), $urandom_range(1), $urandom_range(1));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(15) == 0)
        send(2'($urandom_range(2)), coord(), coord(), coord(), $urandom,
             $urandom_range(1), $urandom_range(1), $urandom_range(1));
      plane(i == n - 1);
    end
  endtask

  task automatic run_phase(int sidle, int ridle, int brushes);
    send_idle = sidle;
    recv_idle = ridle;
    for (int b = 0; b < brushes; b++) brush();
  endtask

  initial begin
    int sent;
    rst = 1;
    wr_en = 0;
    wr_data = '0;
    item.valid = 0;
    item.cmd = CMD_START;
    item.vec_x = 0; item.vec_y = 0; item.vec_z = 0;
    item.plane_dist = 0;
    item.is_bevel = 0; item.point_mode = 0; item.last_plane = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // start solid with zero delta: all solid
    send(CMD_PLANE, 32'sh10000, 0, 0, 32'sh10000, 0, 0, 1);
    // point ray crossing x = 4 from x = 0 to x = 8
    send(CMD_EXTENT, 0, 0, 0, 0, 0, 1, 0);
    send(CMD_DELTA, 32'sh80000, 0, 0, 0, 0, 0, 0);
    send(CMD_PLANE, -32'sh10000, 0, 0, -32'sh40000, 0, 0, 0);
    send(CMD_PLANE, 32'sh10000, 0, 0, 32'sh100000, 1, 0, 0);
    send(CMD_PLANE, 32'sh10000, 0, 0, 32'sh1000, 0, 0, 1);
    // rejected: start outside, moving away, then more ignored planes
    send(CMD_PLANE, 32'sh10000, 0, 0, -32'sh10000, 0, 0, 0);
    send(CMD_PLANE, -32'sh10000, 0, 0, 32'sh1000000, 0, 0, 1);
    // swept box, extremes of every field
    send(CMD_EXTENT, 32'sh7fffffff, 32'sh80000000, 32'sh10000, 0, 1, 0, 1);
    send(CMD_START, 32'sh80000000, 32'sh7fffffff, -1, 32'sh7fffffff, 1, 1, 1);
    send(CMD_DELTA, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, -1, 1, 1, 1);
    send(CMD_PLANE, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1, 1, 0);
    send(CMD_PLANE, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1, 0, 1);
    // bevel closing a brush in ray mode
    send(CMD_START, 0, 0, 0, 0, 0, 0, 0);
    send(CMD_EXTENT, 32'sh8000, 32'sh8000, 32'sh8000, 0, 0, 1, 0);
    send(CMD_DELTA, 32'sh20000, 32'sh20000, 0, 0, 0, 0, 0);
    send(CMD_PLANE, 0, -32'sh10000, 0, -32'sh10000, 0, 0, 0);
    send(CMD_PLANE, 0, 32'sh10000, 0, 0, 1, 0, 1);

    write_eps(16'd0);
    run_phase(0, 0, 25);
    write_eps(16'hffff);
    run_phase(52, 0, 25);

    // fill the block while the output is held off
    hold_req = 1;
    for (int i = 0; i < 10; i++) brush();

    write_eps(16'($urandom));
    run_phase(0, 52, 25);
    go_quiet();
    run_phase(14, 14, 25);
    write_eps(16'd2048);
    sent = 0;
    while (sent < 10) begin
      run_phase($urandom_range(1) ? 0 : 52, $urandom_range(1) ? 0 : 52, 1);
      sent++;
    end

    go_quiet();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: swept_box_brush_trace.f
rtl/bst_pkg.sv
rtl/bst_item_if.sv
rtl/bst_result_if.sv
rtl/bst_mul.sv
rtl/bst_div.sv
rtl/swept_box_brush_trace.sv
test/swept_box_brush_trace_tb.sv
